[hdl/dpsp_pkg.sv]
package dpsp_pkg;

  localparam int SampleW = 12;
  localparam int FiltW   = 20;
  localparam int TravW   = 16;
  localparam int TimeW   = 32;
  localparam int WeightW = 16;
  localparam int CfgW    = 16;
  localparam int DivSteps = 16;
  localparam int DivCntW  = $clog2(DivSteps);

  // Window limits in ADC counts and throttle hysteresis in Q0.16.
  localparam logic [SampleW-1:0] WINDOW_A_LOW  = 12'd200;
  localparam logic [SampleW-1:0] WINDOW_A_HIGH = 12'd3900;
  localparam logic [SampleW-1:0] WINDOW_B_LOW  = 12'd200;
  localparam logic [SampleW-1:0] WINDOW_B_HIGH = 12'd3900;
  localparam logic [TravW-1:0]   THROTTLE_ON   = 16'd16384;
  localparam logic [TravW-1:0]   THROTTLE_OFF  = 16'd3277;

  localparam logic [15:0] RST_FILTER_WEIGHT  = 16'd16384;
  localparam logic [11:0] RST_SENSOR1_ZERO   = 12'd400;
  localparam logic [11:0] RST_SENSOR1_FULL   = 12'd3700;
  localparam logic [11:0] RST_SENSOR2_ZERO   = 12'd400;
  localparam logic [11:0] RST_SENSOR2_FULL   = 12'd3700;
  localparam logic [15:0] RST_FAULT_HOLD_MS  = 16'd100;
  localparam logic [15:0] RST_DISAGREE_LIMIT = 16'd6554;
  localparam logic [11:0] RST_BRAKE_LIMIT    = 12'd100;

  typedef enum logic [2:0] {
    REG_FILTER_WEIGHT,
    REG_SENSOR1_ZERO,
    REG_SENSOR1_FULL,
    REG_SENSOR2_ZERO,
    REG_SENSOR2_FULL,
    REG_FAULT_HOLD_MS,
    REG_DISAGREE_LIMIT,
    REG_BRAKE_LIMIT
  } reg_index_t;

  typedef struct packed {
    logic [15:0] filter_weight;
    logic [11:0] sensor1_zero;
    logic [11:0] sensor1_full;
    logic [11:0] sensor2_zero;
    logic [11:0] sensor2_full;
    logic [15:0] fault_hold_ms;
    logic [15:0] disagree_limit;
    logic [11:0] brake_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_UPD_A,
    S_MUL_B,
    S_UPD_B,
    S_PREP_A,
    S_DIV_A,
    S_PREP_B,
    S_DIV_B,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic prep;
    logic div_step;
    logic fin;
    logic sel;
  } dp_cmd_t;

  typedef struct packed {
    logic early;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

[hdl/dpsp_regs.sv]
module dpsp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic [2:0]                 index,
  input  logic [dpsp_pkg::CfgW-1:0]  data,
  output dpsp_pkg::cfg_t             cfg
);
  import dpsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_weight  <= RST_FILTER_WEIGHT;
      cfg.sensor1_zero   <= RST_SENSOR1_ZERO;
      cfg.sensor1_full   <= RST_SENSOR1_FULL;
      cfg.sensor2_zero   <= RST_SENSOR2_ZERO;
      cfg.sensor2_full   <= RST_SENSOR2_FULL;
      cfg.fault_hold_ms  <= RST_FAULT_HOLD_MS;
      cfg.disagree_limit <= RST_DISAGREE_LIMIT;
      cfg.brake_limit    <= RST_BRAKE_LIMIT;
    end else if (wr) begin
      case (reg_index_t'(index))
        REG_FILTER_WEIGHT:  cfg.filter_weight  <= data;
        REG_SENSOR1_ZERO:   cfg.sensor1_zero   <= data[11:0];
        REG_SENSOR1_FULL:   cfg.sensor1_full   <= data[11:0];
        REG_SENSOR2_ZERO:   cfg.sensor2_zero   <= data[11:0];
        REG_SENSOR2_FULL:   cfg.sensor2_full   <= data[11:0];
        REG_FAULT_HOLD_MS:  cfg.fault_hold_ms  <= data;
        REG_DISAGREE_LIMIT: cfg.disagree_limit <= data;
        REG_BRAKE_LIMIT:    cfg.brake_limit    <= data[11:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/dpsp_datapath.sv]
module dpsp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dpsp_pkg::cfg_t                cfg,
  input  dpsp_pkg::dp_cmd_t             cmd,
  output dpsp_pkg::dp_stat_t            stat,
  input  logic [dpsp_pkg::SampleW-1:0]  pedal_sample_a,
  input  logic [dpsp_pkg::SampleW-1:0]  pedal_sample_b,
  input  logic [dpsp_pkg::SampleW-1:0]  brake_front,
  input  logic [dpsp_pkg::SampleW-1:0]  brake_rear,
  input  logic [dpsp_pkg::TimeW-1:0]    now_ms,
  input  logic                          result_stall,
  output logic                          result_valid,
  output logic [dpsp_pkg::TravW-1:0]    throttle,
  output logic [dpsp_pkg::TravW-1:0]    travel_a,
  output logic [dpsp_pkg::TravW-1:0]    travel_b,
  output logic                          pedal_fault,
  output logic                          brake_plausibility_fault
);
  import dpsp_pkg::*;

  localparam int ProdW = FiltW + WeightW;
  localparam int RemW  = FiltW + 8;

  // Captured request.
  logic [SampleW-1:0] smp_a, smp_b, brk_f, brk_r;
  logic [TimeW-1:0]   now_r;

  // Item-to-item state.
  logic [FiltW-1:0] filt_a, filt_b;
  logic [TimeW-1:0] last_healthy;
  logic             latch;

  // Work registers.
  logic [ProdW-1:0]   prod;
  logic               prod_neg;
  logic [TravW-1:0]   trav_a, trav_b;
  logic [RemW-1:0]    rem;
  logic [RemW-2:0]    dsh;
  logic [TravW-1:0]   quo;
  logic [DivCntW-1:0] cnt;

  // Operand selection for the shared multiplier and divider.
  logic [FiltW-1:0]   f_sel;
  logic [SampleW-1:0] s_sel;
  logic [SampleW-1:0] zero_sel, full_sel;

  logic signed [FiltW:0] diff;
  logic [FiltW-1:0]      mag;
  logic [FiltW-1:0]      dmag;
  logic [FiltW-1:0]      f_new;

  logic signed [FiltW+1:0] num, n;
  logic signed [SampleW:0] span;
  logic [SampleW-1:0]      dv;
  logic                    n_pos;
  logic [TravW-1:0]        early_val;

  logic              ge;
  logic [TravW-1:0]  quo_final;

  logic [TravW:0]     sum;
  logic [TravW-1:0]   thr, dif;
  logic               oow_a, oow_b, oow;
  logic [TimeW-1:0]   elapsed;
  logic               fault;
  logic [SampleW-1:0] brake;
  logic               latch_next;

  always_comb begin
    f_sel    = cmd.sel ? filt_b : filt_a;
    s_sel    = cmd.sel ? smp_b : smp_a;
    zero_sel = cmd.sel ? cfg.sensor2_zero : cfg.sensor1_zero;
    full_sel = cmd.sel ? cfg.sensor2_full : cfg.sensor1_full;

    // Low-pass: f + floor((x8 - f) * w / 65536), rounding toward minus infinity.
    diff = $signed({1'b0, s_sel, 8'b0}) - $signed({1'b0, f_sel});
    mag  = diff[FiltW] ? FiltW'(-diff) : diff[FiltW-1:0];
    dmag = prod_neg ? FiltW'((ProdW'(prod) + ProdW'(16'hFFFF)) >> 16)
                    : prod[ProdW-1:16];
    f_new = prod_neg ? f_sel - dmag : f_sel + dmag;

    // Linear map; an inverted sensor negates both numerator and span.
    num  = $signed({2'b0, f_sel}) - $signed({2'b0, zero_sel, 8'b0});
    span = $signed({1'b0, full_sel}) - $signed({1'b0, zero_sel});
    n    = span[SampleW] ? -num : num;
    dv   = span[SampleW] ? SampleW'(-span) : span[SampleW-1:0];
    n_pos = !n[FiltW+1] && (n != '0);
    // Travel is settled without dividing when it is zero or saturates.
    stat.early = !n_pos || (dv == '0) || (n[FiltW-1:0] >= {dv, 8'b0});
    early_val  = n_pos ? {TravW{1'b1}} : '0;

    ge        = rem >= {1'b0, dsh};
    quo_final = {quo[TravW-2:0], ge};
    stat.div_last = (cnt == DivCntW'(DivSteps - 1));
    stat.out_busy = result_valid && result_stall;

    sum = {1'b0, trav_a} + {1'b0, trav_b};
    thr = sum[TravW:1];
    dif = (trav_a > trav_b) ? trav_a - trav_b : trav_b - trav_a;
    oow_a = (filt_a < {WINDOW_A_LOW, 8'b0}) || (filt_a > {WINDOW_A_HIGH, 8'b0});
    oow_b = (filt_b < {WINDOW_B_LOW, 8'b0}) || (filt_b > {WINDOW_B_HIGH, 8'b0});
    oow   = oow_a || oow_b;
    elapsed = now_r - last_healthy;
    fault = (oow && (elapsed > {16'b0, cfg.fault_hold_ms})) || (dif > cfg.disagree_limit);
    brake = (brk_r > brk_f) ? brk_r : brk_f;
    if (thr > THROTTLE_ON && brake > cfg.brake_limit) begin
      latch_next = 1'b1;
    end else if (thr < THROTTLE_OFF) begin
      latch_next = 1'b0;
    end else begin
      latch_next = latch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_a <= pedal_sample_a;
      smp_b <= pedal_sample_b;
      brk_f <= brake_front;
      brk_r <= brake_rear;
      now_r <= now_ms;
    end
    if (cmd.mul) begin
      prod     <= {{WeightW{1'b0}}, mag} * {{FiltW{1'b0}}, cfg.filter_weight};
      prod_neg <= diff[FiltW];
    end
    if (cmd.prep) begin
      if (stat.early) begin
        if (cmd.sel) begin
          trav_b <= early_val;
        end else begin
          trav_a <= early_val;
        end
      end
      rem <= {n[FiltW-1:0], 8'b0};
      dsh <= {dv, {(RemW-1-SampleW){1'b0}}};
      cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? rem - {1'b0, dsh} : rem;
      dsh <= dsh >> 1;
      quo <= quo_final;
      cnt <= cnt + 1'b1;
      if (stat.div_last) begin
        if (cmd.sel) begin
          trav_b <= quo_final;
        end else begin
          trav_a <= quo_final;
        end
      end
    end
    if (cmd.fin) begin
      throttle                 <= thr;
      travel_a                 <= trav_a;
      travel_b                 <= trav_b;
      pedal_fault              <= fault;
      brake_plausibility_fault <= latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_a       <= '0;
      filt_b       <= '0;
      last_healthy <= '0;
      latch        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (cmd.sel) begin
          filt_b <= f_new;
        end else begin
          filt_a <= f_new;
        end
      end
      if (cmd.fin) begin
        latch <= latch_next;
        if (!oow) begin
          last_healthy <= now_r;
        end
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_fin_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> result_valid)
    else $error("result not shown after finish");

  a_low_throttle_no_latch: assert property (@(posedge clk) disable iff (rst)
    (result_valid && throttle < THROTTLE_OFF) |-> !brake_plausibility_fault)
    else $error("brake fault held at low throttle");

  a_throttle_is_mean: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (throttle <= travel_a || throttle <= travel_b))
    else $error("throttle above both travels");

endmodule

[hdl/dpsp_ctrl.sv]
module dpsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  dpsp_pkg::dp_stat_t stat,
  output dpsp_pkg::dp_cmd_t  cmd
);
  import dpsp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD_A;
      end
      S_UPD_A: begin
        cmd.upd    = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul    = 1'b1;
        cmd.sel    = 1'b1;
        state_next = S_UPD_B;
      end
      S_UPD_B: begin
        cmd.upd    = 1'b1;
        cmd.sel    = 1'b1;
        state_next = S_PREP_A;
      end
      S_PREP_A: begin
        cmd.prep   = 1'b1;
        state_next = stat.early ? S_PREP_B : S_DIV_A;
      end
      S_DIV_A: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PREP_B;
        end
      end
      S_PREP_B: begin
        cmd.prep   = 1'b1;
        cmd.sel    = 1'b1;
        state_next = stat.early ? S_FIN : S_DIV_B;
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        cmd.sel      = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // Wait while the previous result is still held by the receiver.
        if (!stat.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/dual_pedal_sensor_plausibility.sv]
// Dual pedal sensor plausibility checker.
// Input channel: sample_valid/sample_stall carry two pedal ADC samples, two
// brake pressures and a millisecond timestamp. A request is taken when
// sample_valid is high and sample_stall is low.
// Output channel: result_valid/result_stall carry throttle, both travels,
// pedal_fault and brake_plausibility_fault; one result per request.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no request is in flight.
// A sensor whose travel is not settled early adds a division before the
// result. One request is worked on at a time; the next is taken in the
// cycle after the previous result is loaded. Work is serialised by the
// single restoring divider, one quotient bit per cycle, shared by both
// sensors, and the shared filter multiplier.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its own result waits at the end while result_stall holds.
// Reset clears filter state, timestamp, brake latch and loads register
// defaults; no result is pending after reset.
module dual_pedal_sensor_plausibility (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [dpsp_pkg::SampleW-1:0]  pedal_sample_a,
  input  logic [dpsp_pkg::SampleW-1:0]  pedal_sample_b,
  input  logic [dpsp_pkg::SampleW-1:0]  brake_front,
  input  logic [dpsp_pkg::SampleW-1:0]  brake_rear,
  input  logic [dpsp_pkg::TimeW-1:0]    now_ms,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [dpsp_pkg::TravW-1:0]    throttle,
  output logic [dpsp_pkg::TravW-1:0]    travel_a,
  output logic [dpsp_pkg::TravW-1:0]    travel_b,
  output logic                          pedal_fault,
  output logic                          brake_plausibility_fault,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [dpsp_pkg::CfgW-1:0]     cfg_data
);
  import dpsp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dpsp_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  dpsp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  dpsp_datapath u_dp (
    .clk                      (clk),
    .rst                      (rst),
    .cfg                      (cfg),
    .cmd                      (cmd),
    .stat                     (stat),
    .pedal_sample_a           (pedal_sample_a),
    .pedal_sample_b           (pedal_sample_b),
    .brake_front              (brake_front),
    .brake_rear               (brake_rear),
    .now_ms                   (now_ms),
    .result_stall             (result_stall),
    .result_valid             (result_valid),
    .throttle                 (throttle),
    .travel_a                 (travel_a),
    .travel_b                 (travel_b),
    .pedal_fault              (pedal_fault),
    .brake_plausibility_fault (brake_plausibility_fault)
  );

endmodule
